FILE: design/cifp_pkg.sv
`default_nettype none
package cifp_pkg;

    // default sample width of the phasor parts
    localparam int SAMPLE_WIDTH_DEF = 24;

    // register and result widths
    localparam int REF_W   = 30;
    localparam int POW_W   = 47;
    localparam int RES_W   = 48;
    localparam int CFG_W   = 47;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MOHM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POW  = 2'd1;

    // reset values
    localparam logic [REF_W-1:0] REF_MOHM_RST = 30'd1000000;
    localparam logic [POW_W-1:0] MIN_POW_RST  = 47'd0;

    // saturation limits as magnitudes
    localparam logic [RES_W-1:0] RES_MAXPOS = 48'h7FFF_FFFF_FFFF;
    localparam logic [RES_W-1:0] RES_MAXNEG = 48'h8000_0000_0000;

    // control that travels with each item down the pipeline
    typedef struct packed {
        logic valid;
        logic keep;
        logic neg_re;
        logic neg_im;
    } cifp_ctl_t;

endpackage
`default_nettype wire

FILE: design/complex_impedance_from_phasors.sv
// throughput: one item per cycle unless a result stalls; the quotient is built by a restoring divider
//   with one pipeline stage per numerator bit, so depth grows with sample width
// a stalled result holds the whole pipeline; nothing is lost or repeated
// reset: synchronous active-low aresetn clears all valid bits and loads the
//   registers with 1000000 milliohm and a power threshold of zero
`default_nettype none
module complex_impedance_from_phasors #(
    parameter int SAMPLE_WIDTH = cifp_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration
    input  wire logic                                 cfg_wr_en,
    input  wire logic [cifp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [cifp_pkg::CFG_W-1:0]           cfg_data,
    // phasor input
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       s_source_real,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       s_source_imag,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       s_ref_real,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       s_ref_imag,
    // impedance result
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [cifp_pkg::RES_W-1:0]         m_resistance_part,
    output logic signed [cifp_pkg::RES_W-1:0]         m_reactance_part,
    output logic                                      m_result_valid,
    output logic                                      m_saturated
);
    localparam int W    = SAMPLE_WIDTH;
    localparam int NW   = 2 * W + 2 + cifp_pkg::REF_W;
    localparam int RES  = cifp_pkg::RES_W;
    localparam int XW   = ((NW > RES) ? NW : RES) + 1;

    // configuration registers
    logic [cifp_pkg::REF_W-1:0] ref_mohm_reg;
    logic [cifp_pkg::POW_W-1:0] min_pow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_mohm_reg <= cifp_pkg::REF_MOHM_RST;
            min_pow_reg  <= cifp_pkg::MIN_POW_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cifp_pkg::CFG_REF_MOHM: ref_mohm_reg <= cfg_data[cifp_pkg::REF_W-1:0];
                cifp_pkg::CFG_MIN_POW:  min_pow_reg  <= cfg_data[cifp_pkg::POW_W-1:0];
                default: ; // unknown index, write dropped
            endcase
        end
    end

    // whole pipeline advances while the output register is free or being taken
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // front end: difference, products, power, resistor scaling
    cifp_pkg::cifp_ctl_t   ctl_f, ctl_q;
    logic [NW-1:0]         num_re, num_im;
    logic [2*W-1:0]        den;
    logic [NW-1:0]         q_re, q_im;

    cifp_front #(
        .SAMPLE_WIDTH (W),
        .NW           (NW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .src_re   (s_source_real),
        .src_im   (s_source_imag),
        .ref_re   (s_ref_real),
        .ref_im   (s_ref_imag),
        .ref_mohm (ref_mohm_reg),
        .min_pow  (min_pow_reg),
        .ctl_out  (ctl_f),
        .num_re   (num_re),
        .num_im   (num_im),
        .den      (den)
    );

    // pipelined long division of both parts by the reference power
    cifp_div #(
        .NW   (NW),
        .DENW (2 * W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_in  (ctl_f),
        .num_re  (num_re),
        .num_im  (num_im),
        .den     (den),
        .ctl_out (ctl_q),
        .q_re    (q_re),
        .q_im    (q_im)
    );

    // saturation and sign restore on the quotient magnitudes
    logic [XW-1:0]  qx_re, qx_im, lim_re, lim_im;
    logic           sat_re, sat_im;
    logic [RES-1:0] sel_re, sel_im;
    logic [RES-1:0] res_next, rea_next;
    logic           sat_next;

    always_comb begin
        qx_re  = XW'(q_re);
        qx_im  = XW'(q_im);
        lim_re = ctl_q.neg_re ? XW'(cifp_pkg::RES_MAXNEG) : XW'(cifp_pkg::RES_MAXPOS);
        lim_im = ctl_q.neg_im ? XW'(cifp_pkg::RES_MAXNEG) : XW'(cifp_pkg::RES_MAXPOS);
        sat_re = qx_re > lim_re;
        sat_im = qx_im > lim_im;
        sel_re = sat_re ? lim_re[RES-1:0] : qx_re[RES-1:0];
        sel_im = sat_im ? lim_im[RES-1:0] : qx_im[RES-1:0];
        // weak reference or zero resistor gives all-zero fields
        if (ctl_q.keep) begin
            res_next = ctl_q.neg_re ? -sel_re : sel_re;
            rea_next = ctl_q.neg_im ? -sel_im : sel_im;
            sat_next = sat_re || sat_im;
        end else begin
            res_next = '0;
            rea_next = '0;
            sat_next = 1'b0;
        end
    end

    // output register
    logic [RES-1:0] res_reg, rea_reg;
    logic           rv_reg, sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= ctl_q.valid;
            res_reg     <= res_next;
            rea_reg     <= rea_next;
            rv_reg      <= ctl_q.keep;
            sat_reg     <= sat_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_resistance_part = $signed(res_reg);
    assign m_reactance_part  = $signed(rea_reg);
    assign m_result_valid    = rv_reg;
    assign m_saturated       = sat_reg;

endmodule
`default_nettype wire

FILE: design/cifp_front.sv
`default_nettype none
module cifp_front #(
    parameter int SAMPLE_WIDTH = cifp_pkg::SAMPLE_WIDTH_DEF,
    parameter int NW = 2 * SAMPLE_WIDTH + 2 + cifp_pkg::REF_W
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    src_re,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    src_im,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    ref_re,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    ref_im,
    input  wire logic [cifp_pkg::REF_W-1:0]        ref_mohm,
    input  wire logic [cifp_pkg::POW_W-1:0]        min_pow,
    output cifp_pkg::cifp_ctl_t                    ctl_out,
    output logic [NW-1:0]                          num_re,
    output logic [NW-1:0]                          num_im,
    output logic [2*SAMPLE_WIDTH-1:0]              den
);
    localparam int W    = SAMPLE_WIDTH;
    localparam int PW   = 2 * W + 1;
    localparam int MW   = 2 * W + 2;
    localparam int HALF = (MW + 1) / 2;
    localparam int HIW  = MW - HALF;
    localparam int RW   = cifp_pkg::REF_W;
    localparam int CMPW = (2 * W > cifp_pkg::POW_W) ? 2 * W : cifp_pkg::POW_W;

    // stage a: difference voltage
    logic              va_reg;
    logic signed [W:0] dre_reg, dim_reg;
    logic signed [W-1:0] vr_reg, vi_reg;

    // stage b: products
    logic              vb_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg;
    logic signed [2*W-1:0] sq_r_reg, sq_i_reg;

    // stage c: sums, magnitudes, validity
    cifp_pkg::cifp_ctl_t ctl_c_reg, ctl_c_next;
    logic [MW-1:0]  mag_re_reg, mag_im_reg, mag_re_next, mag_im_next;
    logic [2*W-1:0] den_c_reg, den_c_next;
    logic signed [MW-1:0] nre, nim;

    // stage d: partial products with the resistor
    cifp_pkg::cifp_ctl_t ctl_d_reg;
    logic [2*W-1:0]     den_d_reg;
    logic [HALF+RW-1:0] lo_re_reg, lo_im_reg;
    logic [HIW+RW-1:0]  hi_re_reg, hi_im_reg;

    // stage e: full numerators
    cifp_pkg::cifp_ctl_t ctl_e_reg;
    logic [2*W-1:0] den_e_reg;
    logic [NW-1:0]  num_re_reg, num_im_reg;

    always_comb begin
        nre = p_rr_reg + p_ii_reg;
        nim = p_ir_reg - p_ri_reg;
        den_c_next = $unsigned(sq_r_reg) + $unsigned(sq_i_reg);
        ctl_c_next.valid  = vb_reg;
        ctl_c_next.keep   = (ref_mohm != '0) && (CMPW'(den_c_next) > CMPW'(min_pow));
        ctl_c_next.neg_re = nre[MW-1];
        ctl_c_next.neg_im = nim[MW-1];
        mag_re_next = nre[MW-1] ? $unsigned(-nre) : $unsigned(nre);
        mag_im_next = nim[MW-1] ? $unsigned(-nim) : $unsigned(nim);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg          <= 1'b0;
            vb_reg          <= 1'b0;
            ctl_c_reg.valid <= 1'b0;
            ctl_d_reg.valid <= 1'b0;
            ctl_e_reg.valid <= 1'b0;
        end else if (en) begin
            va_reg  <= in_valid;
            dre_reg <= $signed({src_re[W-1], src_re}) - $signed({ref_re[W-1], ref_re});
            dim_reg <= $signed({src_im[W-1], src_im}) - $signed({ref_im[W-1], ref_im});
            vr_reg  <= ref_re;
            vi_reg  <= ref_im;

            vb_reg   <= va_reg;
            p_rr_reg <= dre_reg * vr_reg;
            p_ii_reg <= dim_reg * vi_reg;
            p_ir_reg <= dim_reg * vr_reg;
            p_ri_reg <= dre_reg * vi_reg;
            sq_r_reg <= vr_reg * vr_reg;
            sq_i_reg <= vi_reg * vi_reg;

            ctl_c_reg  <= ctl_c_next;
            mag_re_reg <= mag_re_next;
            mag_im_reg <= mag_im_next;
            den_c_reg  <= den_c_next;

            ctl_d_reg <= ctl_c_reg;
            den_d_reg <= den_c_reg;
            lo_re_reg <= (HALF+RW)'(mag_re_reg[HALF-1:0]) * (HALF+RW)'(ref_mohm);
            lo_im_reg <= (HALF+RW)'(mag_im_reg[HALF-1:0]) * (HALF+RW)'(ref_mohm);
            hi_re_reg <= (HIW+RW)'(mag_re_reg[MW-1:HALF]) * (HIW+RW)'(ref_mohm);
            hi_im_reg <= (HIW+RW)'(mag_im_reg[MW-1:HALF]) * (HIW+RW)'(ref_mohm);

            ctl_e_reg  <= ctl_d_reg;
            den_e_reg  <= den_d_reg;
            num_re_reg <= (NW'(hi_re_reg) << HALF) + NW'(lo_re_reg);
            num_im_reg <= (NW'(hi_im_reg) << HALF) + NW'(lo_im_reg);
        end
    end

    assign ctl_out = ctl_e_reg;
    assign num_re  = num_re_reg;
    assign num_im  = num_im_reg;
    assign den     = den_e_reg;

endmodule
`default_nettype wire

FILE: design/cifp_div.sv
`default_nettype none
module cifp_div #(
    parameter int NW   = 80,
    parameter int DENW = 48
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire cifp_pkg::cifp_ctl_t ctl_in,
    input  wire logic [NW-1:0]       num_re,
    input  wire logic [NW-1:0]       num_im,
    input  wire logic [DENW-1:0]     den,
    output cifp_pkg::cifp_ctl_t      ctl_out,
    output logic [NW-1:0]            q_re,
    output logic [NW-1:0]            q_im
);
    // one restoring step per stage, two lanes sharing the divisor;
    // dividend bits shift out at the top while quotient bits shift in below
    cifp_pkg::cifp_ctl_t ctl_reg [NW];
    logic [DENW-1:0] den_reg [NW];
    logic [NW-1:0]   nq_reg  [NW][2];
    logic [DENW-1:0] rem_reg [NW][2];

    cifp_pkg::cifp_ctl_t ctl_src [NW];
    logic [DENW-1:0] den_src [NW];
    logic [NW-1:0]   nq_src  [NW][2];
    logic [DENW-1:0] rem_src [NW][2];
    logic [NW-1:0]   nq_next  [NW][2];
    logic [DENW-1:0] rem_next [NW][2];
    logic [DENW:0]   trial [NW][2];
    logic [DENW:0]   diff  [NW][2];
    logic            ge    [NW][2];

    always_comb begin
        for (int k = 0; k < NW; k++) begin
            if (k == 0) begin
                ctl_src[k]    = ctl_in;
                den_src[k]    = den;
                nq_src[k][0]  = num_re;
                nq_src[k][1]  = num_im;
                rem_src[k][0] = '0;
                rem_src[k][1] = '0;
            end else begin
                ctl_src[k]    = ctl_reg[k-1];
                den_src[k]    = den_reg[k-1];
                nq_src[k][0]  = nq_reg[k-1][0];
                nq_src[k][1]  = nq_reg[k-1][1];
                rem_src[k][0] = rem_reg[k-1][0];
                rem_src[k][1] = rem_reg[k-1][1];
            end
            for (int j = 0; j < 2; j++) begin
                trial[k][j]    = {rem_src[k][j], nq_src[k][j][NW-1]};
                diff[k][j]     = trial[k][j] - {1'b0, den_src[k]};
                ge[k][j]       = trial[k][j] >= {1'b0, den_src[k]};
                rem_next[k][j] = ge[k][j] ? diff[k][j][DENW-1:0] : trial[k][j][DENW-1:0];
                nq_next[k][j]  = {nq_src[k][j][NW-2:0], ge[k][j]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NW; k++) begin
            if (!aresetn) begin
                ctl_reg[k].valid <= 1'b0;
            end else if (en) begin
                ctl_reg[k] <= ctl_src[k];
                den_reg[k] <= den_src[k];
                for (int j = 0; j < 2; j++) begin
                    nq_reg[k][j]  <= nq_next[k][j];
                    rem_reg[k][j] <= rem_next[k][j];
                end
            end
        end
    end

    assign ctl_out = ctl_reg[NW-1];
    assign q_re    = nq_reg[NW-1][0];
    assign q_im    = nq_reg[NW-1][1];

endmodule
`default_nettype wire

FILE: design/cifp_checker.sv
`default_nettype none
module cifp_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_ready,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [cifp_pkg::RES_W-1:0]        m_resistance_part,
    input wire logic [cifp_pkg::RES_W-1:0]        m_reactance_part,
    input wire logic                              m_result_valid,
    input wire logic                              m_saturated
);
    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_resistance_part)
            && $stable(m_reactance_part) && $stable(m_result_valid))
        else $error("result changed while stalled");

    // input side stalls only while a result waits
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output stall");

    // invalid result carries zero fields
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result_valid |-> m_resistance_part == '0
            && m_reactance_part == '0 && !m_saturated)
        else $error("invalid result with non-zero fields");

    // clamping only on valid results
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_result_valid)
        else $error("saturated flag on invalid result");

endmodule

bind complex_impedance_from_phasors cifp_checker u_cifp_checker (.*);
`default_nettype wire

FILE: verif/complex_impedance_from_phasors_test.sv
`timescale 1ns / 100ps
`default_nettype none

// impedance scoreboard: holds the register copy and the queue of predicted results
class impedance_scoreboard;
    typedef struct {
        logic signed [47:0] re;
        logic signed [47:0] im;
        logic               ok;
        logic               sat;
    } z_t;

    logic [29:0] ref_mohm;
    logic [46:0] min_pow;
    logic [63:0] power_cur;
    z_t          pending_z[$];
    int          errors;

    function void reset_regs();
        ref_mohm = cifp_pkg::REF_MOHM_RST;
        min_pow  = cifp_pkg::MIN_POW_RST;
    endfunction

    function void write_reg(logic [1:0] idx, logic [46:0] val);
        if (idx == cifp_pkg::CFG_REF_MOHM) ref_mohm = val[29:0];
        else if (idx == cifp_pkg::CFG_MIN_POW) min_pow = val;
    endfunction

    // signed numerator times resistor over power, truncated and clamped
    function logic signed [47:0] scaled_div(logic signed [63:0] num, ref logic sat);
        logic          neg_num;
        logic [127:0]  mag, q, lim;
        neg_num = num < 0;
        mag = neg_num ? 128'(-num) : 128'(num);
        q = (mag * 128'(ref_mohm)) / 128'(power_cur);
        lim = neg_num ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
        if (q > lim) begin
            sat = 1'b1;
            q = lim;
        end
        return neg_num ? -q[47:0] : q[47:0];
    endfunction

    function void note_phasors(logic signed [23:0] sr, si, vr, vi);
        z_t z;
        logic signed [63:0] dr, di, nre, nim;
        logic sat;
        z = '{default: '0};
        sat = 1'b0;
        power_cur = 64'(64'(vr) * 64'(vr)) + 64'(64'(vi) * 64'(vi));
        if (ref_mohm != 0 && power_cur > 64'(min_pow)) begin
            dr = 64'(sr) - 64'(vr);
            di = 64'(si) - 64'(vi);
            nre = dr * 64'(vr) + di * 64'(vi);
            nim = di * 64'(vr) - dr * 64'(vi);
            z.re = scaled_div(nre, sat);
            z.im = scaled_div(nim, sat);
            z.ok = 1'b1;
            z.sat = sat;
        end
        pending_z.push_back(z);
    endfunction

    function void check_result(logic signed [47:0] re, im, logic ok, sat);
        z_t z;
        if (pending_z.size() == 0) begin
            $display("%0t: result with none expected re %0d im %0d", $time, re, im);
            errors++;
            return;
        end
        z = pending_z.pop_front();
        if (re !== z.re || im !== z.im || ok !== z.ok || sat !== z.sat) begin
            $display({"%0t: mismatch expected re %0d im %0d ok %0b sat %0b,",
                      " actual re %0d im %0d ok %0b sat %0b"},
                     $time, z.re, z.im, z.ok, z.sat, re, im, ok, sat);
            errors++;
        end
    endfunction
endclass

module complex_impedance_from_phasors_test;

    localparam int LATENCY = 2 * 24 + 38;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [cifp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [cifp_pkg::CFG_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [23:0] s_source_real = '0, s_source_imag = '0;
    logic signed [23:0] s_ref_real = '0, s_ref_imag = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [cifp_pkg::RES_W-1:0] m_resistance_part, m_reactance_part;
    logic m_result_valid, m_saturated;

    impedance_scoreboard board = new();
    bit stimulus_done = 1'b0;

    complex_impedance_from_phasors u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_source_real(s_source_real), .s_source_imag(s_source_imag),
        .s_ref_real(s_ref_real), .s_ref_imag(s_ref_imag),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_resistance_part(m_resistance_part), .m_reactance_part(m_reactance_part),
        .m_result_valid(m_result_valid), .m_saturated(m_saturated)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // generous limit: worst case each item waits out a random input gap and a random output stall plus pipeline
    initial begin
        #(8 * 4000000);
        $display("TB_ERROR");
        $finish;
    end

    // register write, only while the pipeline is empty; the bench idles after it
    task automatic write_cfg(logic [cifp_pkg::CFG_IDX_W-1:0] idx,
                             logic [cifp_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.write_reg(idx, val);
        @(posedge aclk);
    endtask

    // one phasor transfer with a random gap before it
    task automatic send_phasors(logic signed [23:0] sr, si, vr, vi, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_source_real <= sr;
        s_source_imag <= si;
        s_ref_real <= vr;
        s_ref_imag <= vi;
        do @(posedge aclk); while (!s_ready);
        board.note_phasors(sr, si, vr, vi);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending_z.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic signed [23:0] rand_sample(int mode);
        case (mode)
            0: return $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
            1: return 24'($signed($urandom_range(0, 64)) - 32);
            2: return 24'($signed($urandom_range(0, 8192)) - 4096);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_phase(int count, bit bursty);
        repeat (count) begin
            send_phasors(rand_sample($urandom_range(0, 3)), rand_sample($urandom_range(0, 3)),
                         rand_sample($urandom_range(0, 3)), rand_sample($urandom_range(0, 3)),
                         bursty);
        end
        drain();
    endtask

    // result side: random stall per result, sampled at the edge
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = stimulus_done ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            board.check_result(m_resistance_part, m_reactance_part,
                               m_result_valid, m_saturated);
        end
    end

    initial begin
        board.reset_regs();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, zero reference, weak reference, clamping
        send_phasors(24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000, -24'sh800000);
        send_phasors(-24'sh800000, -24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
        send_phasors(24'sd0, 24'sd0, 24'sd0, 24'sd0);
        send_phasors(24'sd100, 24'sd50, 24'sd10, 24'sd0);
        send_phasors(-24'sh800000, 24'sh7FFFFF, 24'sd1, 24'sd0);
        send_phasors(24'sh7FFFFF, -24'sh800000, 24'sd0, -24'sd1);
        send_phasors(24'sd3, -24'sd7, 24'sd2, 24'sd5);
        drain();
        write_cfg(cifp_pkg::CFG_REF_MOHM, 47'd1000000000);
        send_phasors(24'sh7FFFFF, -24'sh800000, 24'sd1, 24'sd1);
        send_phasors(24'sd5, 24'sd5, -24'sd3, 24'sd4);
        send_phasors(-24'sd1, 24'sd0, 24'sd1, 24'sd0);
        drain();
        write_cfg(cifp_pkg::CFG_REF_MOHM, 47'd1);
        write_cfg(cifp_pkg::CFG_MIN_POW, 47'd25);
        send_phasors(24'sd9, 24'sd9, 24'sd3, 24'sd4);   // at threshold: invalid
        send_phasors(24'sd9, 24'sd9, 24'sd3, 24'sd5);
        send_phasors(24'sd100000, -24'sd7, 24'sd5, 24'sd1);
        drain();
        write_cfg(cifp_pkg::CFG_MIN_POW, 47'h7FFF_FFFF_FFFF);   // only a full-scale negative reference passes
        send_phasors(24'sh7FFFFF, 24'sd0, -24'sh800000, -24'sh800000);
        drain();
        write_cfg(cifp_pkg::CFG_REF_MOHM, 47'd0);                 // zero resistor
        write_cfg(cifp_pkg::CFG_MIN_POW, 47'd0);
        send_phasors(24'sd8, 24'sd1, 24'sd2, 24'sd3);
        drain();

        // random phases over several register settings
        write_cfg(cifp_pkg::CFG_REF_MOHM, 47'(cifp_pkg::REF_MOHM_RST));
        random_phase(300, 0);
        random_phase(150, 1);
        write_cfg(cifp_pkg::CFG_REF_MOHM, 47'd1000000000);
        write_cfg(cifp_pkg::CFG_MIN_POW, 47'd1000);
        random_phase(300, 0);
        write_cfg(cifp_pkg::CFG_REF_MOHM, 47'd1);
        write_cfg(cifp_pkg::CFG_MIN_POW, 47'd10000000);
        random_phase(250, 0);
        write_cfg(cifp_pkg::CFG_REF_MOHM, 47'($urandom_range(1, 1000000000)));
        write_cfg(cifp_pkg::CFG_MIN_POW, {15'd0, 32'($urandom)});
        random_phase(200, 1);
        write_cfg(cifp_pkg::CFG_REF_MOHM, 47'd0);
        random_phase(50, 0);
        write_cfg(cifp_pkg::CFG_REF_MOHM, 47'h7FFF_FFFF_FFFF);    // upper bits dropped
        write_cfg(cifp_pkg::CFG_MIN_POW, 47'h7FFF_FFFF_FFFF);
        random_phase(20, 0);
        write_cfg(cifp_pkg::CFG_MIN_POW, 47'd0);
        random_phase(60, 0);

        stimulus_done = 1'b1;
        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
